@@ hw/rtl/lax_der_signature_parser_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lax DER signature parser
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LAX_DER_SIGNATURE_PARSER_TOP_ASSERT_SVH
`define LAX_DER_SIGNATURE_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LDS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LDS_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LDS_ASSERT(label, clk, rst_n, prop, msg)
`define LDS_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ hw/rtl/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// lds_pkg
// Shared constants, types and helpers of the lax DER signature parser.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int SCALAR_BYTES  = 32;
	localparam int STORE_W       = SCALAR_BYTES * 8;
	localparam int MAX_LEN_BYTES = 3;
	localparam int LEN_W         = 8 * MAX_LEN_BYTES;
	localparam int LEFT_W        = 7;
	localparam int SC_W          = $clog2(SCALAR_BYTES + 2);
	localparam int VIEW_W        = 256;
	localparam int WORD_W        = 64;
	localparam int WORDS         = 8;
	localparam int IDX_W         = 3;
	localparam int OUT_TDATA_W   = 72;

	localparam logic [7:0] TAG_SEQ   = 8'h30;
	localparam logic [7:0] TAG_INT   = 8'h02;
	localparam logic [7:0] LONG_FORM = 8'h80;

	localparam logic [VIEW_W-1:0] GROUP_ORDER =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// one finished signature, as handed from parser to emitter
	typedef struct packed {
		logic [STORE_W-1:0] r_val;
		logic [STORE_W-1:0] s_val;
		logic               fail;
		logic               ovf;
	} rec_t;

	// 256-bit big-endian view of a store, zero-extended when narrower
	function automatic logic [VIEW_W-1:0] store_view(input logic [STORE_W-1:0] st);
		logic [VIEW_W-1:0] v;
		v = '0;
		for (int i = 0; i < VIEW_W; i++) begin
			if (i < STORE_W) v[i] = st[i];
		end
		return v;
	endfunction

	// true when the stored value is at or above the group order
	function automatic logic not_below_order(input logic [STORE_W-1:0] st);
		logic hi;
		hi = 1'b0;
		for (int i = VIEW_W; i < STORE_W; i++) begin
			hi = hi | st[i];
		end
		return hi || (store_view(st) >= GROUP_ORDER);
	endfunction

endpackage

@@ hw/rtl/lds_parser.sv @@
// ----------------------------------------------------------------------------
// lds_parser
// Front end: walks DER one beat per cycle if the queue has room; builds R, S.
// ----------------------------------------------------------------------------
module lds_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output logic          rec_push,
	output lds_pkg::rec_t rec,
	input  logic          rec_full
);
	import lds_pkg::*;

	typedef enum logic [11:0] {
		PH_SEQ_TAG  = 12'b0000_0000_0001,
		PH_SEQ_LEN  = 12'b0000_0000_0010,
		PH_SEQ_SKIP = 12'b0000_0000_0100,
		PH_R_TAG    = 12'b0000_0000_1000,
		PH_R_LEN    = 12'b0000_0001_0000,
		PH_R_LENX   = 12'b0000_0010_0000,
		PH_R_VAL    = 12'b0000_0100_0000,
		PH_S_TAG    = 12'b0000_1000_0000,
		PH_S_LEN    = 12'b0001_0000_0000,
		PH_S_LENX   = 12'b0010_0000_0000,
		PH_S_VAL    = 12'b0100_0000_0000,
		PH_DONE     = 12'b1000_0000_0000
	} phase_t;

	phase_t             phase_q, nx_phase;
	logic [LEN_W-1:0]   len_q, nx_len, bv_cnt;
	logic [LEFT_W-1:0]  left_q, nx_left;
	logic [STORE_W-1:0] r_q, s_q, nx_r, nx_s;
	logic [SC_W-1:0]    sc_q, nx_sc, sc_new;
	logic               zs_q, nx_zs, ovf_q, nx_ovf, fail_q, nx_fail;
	logic               bv_req, bv_is_r, is_r, lenx_fail, take;

	assign byte_ready = !rec_full;
	assign take       = byte_valid && byte_ready;

	always_comb begin
		nx_phase  = phase_q;
		nx_len    = len_q;
		nx_left   = left_q;
		nx_r      = r_q;
		nx_s      = s_q;
		nx_sc     = sc_q;
		nx_zs     = zs_q;
		nx_ovf    = ovf_q;
		nx_fail   = fail_q;
		bv_req    = 1'b0;
		bv_cnt    = '0;
		bv_is_r   = 1'b0;
		is_r      = 1'b0;
		lenx_fail = 1'b0;
		sc_new    = sc_q;
		if (!fail_q) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					if (data_byte != TAG_SEQ) nx_fail = 1'b1;
					else nx_phase = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					nx_phase = PH_R_TAG;
					if ((data_byte & LONG_FORM) != 8'h00) begin
						nx_left = data_byte[LEFT_W-1:0];
						if (data_byte[LEFT_W-1:0] != '0) nx_phase = PH_SEQ_SKIP;
					end
				end
				PH_SEQ_SKIP: begin
					nx_left = left_q - LEFT_W'(1);
					if (left_q == LEFT_W'(1)) nx_phase = PH_R_TAG;
				end
				PH_R_TAG, PH_S_TAG: begin
					if (data_byte != TAG_INT) nx_fail = 1'b1;
					else nx_phase = (phase_q == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
				end
				PH_R_LEN, PH_S_LEN: begin
					is_r = (phase_q == PH_R_LEN);
					if ((data_byte & LONG_FORM) != 8'h00) begin
						nx_left = data_byte[LEFT_W-1:0];
						nx_len  = '0;
						nx_zs   = 1'b1;
						if (data_byte[LEFT_W-1:0] == '0) begin
							bv_req  = 1'b1;
							bv_is_r = is_r;
						end else begin
							nx_phase = is_r ? PH_R_LENX : PH_S_LENX;
						end
					end else begin
						bv_req  = 1'b1;
						bv_is_r = is_r;
						bv_cnt  = LEN_W'(data_byte);
					end
				end
				PH_R_LENX, PH_S_LENX: begin
					is_r      = (phase_q == PH_R_LENX);
					// too many significant length bytes left
					lenx_fail = zs_q && (data_byte != 8'h00) &&
						(left_q > LEFT_W'(MAX_LEN_BYTES));
					if (lenx_fail) begin
						nx_fail = 1'b1;
					end else begin
						if (!(zs_q && data_byte == 8'h00)) begin
							nx_zs  = 1'b0;
							nx_len = (len_q << 8) | LEN_W'(data_byte);
						end
						nx_left = left_q - LEFT_W'(1);
						if (left_q == LEFT_W'(1)) begin
							bv_req  = 1'b1;
							bv_is_r = is_r;
							bv_cnt  = nx_len;
						end
					end
				end
				PH_R_VAL, PH_S_VAL: begin
					is_r = (phase_q == PH_R_VAL);
					if (!(zs_q && data_byte == 8'h00)) begin
						nx_zs  = 1'b0;
						sc_new = sc_q + SC_W'(sc_q <= SC_W'(SCALAR_BYTES));
						nx_sc  = sc_new;
						if (sc_new > SC_W'(SCALAR_BYTES)) begin
							nx_ovf = 1'b1;
						end else if (is_r) begin
							nx_r = (r_q << 8) | STORE_W'(data_byte);
						end else begin
							nx_s = (s_q << 8) | STORE_W'(data_byte);
						end
					end
					nx_len = len_q - LEN_W'(1);
					if (len_q == LEN_W'(1)) begin
						nx_zs    = 1'b1;
						nx_sc    = '0;
						nx_phase = is_r ? PH_S_TAG : PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
		// enter a value field with its byte count
		if (bv_req) begin
			nx_len = bv_cnt;
			nx_zs  = 1'b1;
			nx_sc  = '0;
			if (bv_cnt == '0) nx_phase = bv_is_r ? PH_S_TAG : PH_DONE;
			else nx_phase = bv_is_r ? PH_R_VAL : PH_S_VAL;
		end
	end

	assign rec_push  = take && last_byte;
	assign rec.r_val = nx_r;
	assign rec.s_val = nx_s;
	assign rec.fail  = nx_fail || (nx_phase != PH_DONE);
	assign rec.ovf   = nx_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			len_q   <= '0;
			left_q  <= '0;
			r_q     <= '0;
			s_q     <= '0;
			sc_q    <= '0;
			zs_q    <= 1'b1;
			ovf_q   <= 1'b0;
			fail_q  <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				// frame handed off: start over
				phase_q <= PH_SEQ_TAG;
				len_q   <= '0;
				left_q  <= '0;
				r_q     <= '0;
				s_q     <= '0;
				sc_q    <= '0;
				zs_q    <= 1'b1;
				ovf_q   <= 1'b0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= nx_phase;
				len_q   <= nx_len;
				left_q  <= nx_left;
				r_q     <= nx_r;
				s_q     <= nx_s;
				sc_q    <= nx_sc;
				zs_q    <= nx_zs;
				ovf_q   <= nx_ovf;
				fail_q  <= nx_fail;
			end
		end
	end

endmodule

@@ hw/rtl/lds_queue.sv @@
// ----------------------------------------------------------------------------
// lds_queue
// Two-entry queue of finished signatures between parser and emitter.
// ----------------------------------------------------------------------------
module lds_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lds_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output lds_pkg::rec_t head,
	output logic          not_empty
);
	import lds_pkg::*;

	rec_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ hw/rtl/lds_emitter.sv @@
// ----------------------------------------------------------------------------
// lds_emitter
// Back end: grades one signature and streams its eight words.
// ----------------------------------------------------------------------------
`include "lax_der_signature_parser_top_assert.svh"

module lds_emitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lds_pkg::rec_t                   head,
	input  logic                            head_valid,
	output logic                            pop,
	output logic                            out_tvalid,
	input  logic                            out_tready,
	output logic [lds_pkg::OUT_TDATA_W-1:0] out_tdata,
	output logic                            out_tlast
);
	import lds_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

	logic [2*VIEW_W-1:0] words_q;
	status_t             status_q, ld_status;
	logic [IDX_W-1:0]    idx_q;
	logic                busy_q, done_beat;
	logic [WORD_W-1:0]   word;

	assign done_beat = busy_q && out_tready && (idx_q == LAST_IDX);
	assign pop       = head_valid && (!busy_q || done_beat);

	always_comb begin
		if (head.fail) ld_status = ST_FAIL;
		else if (head.ovf || not_below_order(head.r_val) || not_below_order(head.s_val))
			ld_status = ST_OVF;
		else ld_status = ST_OK;
	end

	assign word       = words_q[(WORDS - 1 - 32'(idx_q)) * WORD_W +: WORD_W];
	assign out_tvalid = busy_q;
	assign out_tlast  = busy_q && (idx_q == LAST_IDX);
	assign out_tdata  = OUT_TDATA_W'({status_q, idx_q, word});

	always_ff @(posedge clk) begin
		if (pop) begin
			// zero the words unless the signature is good
			if (ld_status == ST_OK)
				words_q <= {store_view(head.r_val), store_view(head.s_val)};
			else
				words_q <= '0;
			status_q <= ld_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done_beat) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_tready) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	`LDS_ASSERT(a_zero_words, clk, arst_n, busy_q && status_q != ST_OK |-> word == '0, "words not zeroed on bad status")
	`LDS_ASSERT(a_last_idx, clk, arst_n, out_tlast |-> out_tvalid && idx_q == LAST_IDX, "tlast off the eighth word")
	`LDS_ASSERT(a_drain, clk, arst_n, done_beat && !head_valid |=> !out_tvalid, "emitter busy after final beat")

endmodule

@@ hw/rtl/lax_der_signature_parser_top.sv @@
// ----------------------------------------------------------------------------
// lax_der_signature_parser_top
// Lenient DER ECDSA signature parser: bytes in, eight R/S words out.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                              tlast
//  s_axis    in   data_byte[7:0]                                  last_byte
//  m_axis    out  out_word[63:0] word_index[66:64]                end_of_run
//                 parse_status[68:67] zero[71:69]
//
//  One input beat per cycle while the queue has room. Each finished signature
//  is queued, then loaded into the idle emitter, which offers the first word;
//  the eight words then leave one per cycle while m_axis_tready is high.
//  A two-entry queue sits between parser and emitter; while both entries are
//  taken every input beat stalls, which happens when the output side stalls or
//  words drain slower than signatures arrive.
//  Reset is asynchronous and immediate; there is no clearing pass.
// ----------------------------------------------------------------------------
module lax_der_signature_parser_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // data_byte[7:0]
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_word[63:0], word_index[66:64], parse_status[68:67], zero pad
	output logic [lds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast
);
	import lds_pkg::*;

	rec_t push_rec, head;
	logic push, full, pop, not_empty;

	lds_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_ready (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.last_byte  (s_axis_tlast),
		.rec_push   (push),
		.rec        (push_rec),
		.rec_full   (full)
	);

	lds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	lds_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (not_empty),
		.pop        (pop),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tlast  (m_axis_tlast)
	);

endmodule
